// ----- rtl/frlm_pkg.sv -----
// Package for the ring log manager: word types, command and mark codes,
// control state encoding and default sizes.
// No dependencies.
package frlm_pkg;

    localparam int SECTORS_DEF     = 16;
    localparam int SLOTS_DEF       = 64;
    localparam int OBJECT_BITS_DEF = 32;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 7;
    localparam int SEC_CFG_BITS   = 5;
    localparam int SLOT_CFG_BITS  = 7;

    localparam logic [SEC_CFG_BITS-1:0]  SEC_CFG_RESET  = 5'd16;
    localparam logic [SLOT_CFG_BITS-1:0] SLOT_CFG_RESET = 7'd64;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SECTORS = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLOTS   = 2'd1;

    localparam logic [2:0] CMD_FORMAT  = 3'd0;
    localparam logic [2:0] CMD_APPEND  = 3'd1;
    localparam logic [2:0] CMD_FETCH   = 3'd2;
    localparam logic [2:0] CMD_DISCARD = 3'd3;
    localparam logic [2:0] CMD_REWIND  = 3'd4;

    localparam logic [1:0] MARK_ERASED  = 2'd0;
    localparam logic [1:0] MARK_VALID   = 2'd1;
    localparam logic [1:0] MARK_GARBAGE = 2'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] object_word;
    } in_word_t;

    typedef struct packed {
        logic        status;
        logic [31:0] fetched_word;
        logic [10:0] count_estimate;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FREE,
        ST_APPEND,
        ST_FETCH_RD,
        ST_FETCH_CHK,
        ST_DISCARD,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/flash_ring_log_manager.sv -----
// Ring log manager: rewind and unknown commands go straight to the result;
// an append writes its slot, first sweeping the next sector when that one
// must be erased; fetch scans slots from the current head, discard retires
// slots from the read head up to it, and format clears every slot mark (one
// slot mark cleared a cycle). One command at a time. Reset and every register
// write run a clearing pass over all slot marks; no word is taken meanwhile.
module flash_ring_log_manager
    import frlm_pkg::*;
#(
    parameter int SECTORS     = SECTORS_DEF,
    parameter int SLOTS       = SLOTS_DEF,
    parameter int OBJECT_BITS = OBJECT_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  in_word_t                  in_word,
    output logic                      out_valid,
    input  logic                      out_stall,
    output out_word_t                 out_word,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int TOTAL = SECTORS * SLOTS;
    localparam int AW    = $clog2(TOTAL);
    localparam int SW    = (SECTORS > 1) ? $clog2(SECTORS) : 1;
    localparam int KW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SCW   = $clog2(SECTORS + 1);
    localparam int KCW   = $clog2(SLOTS + 1);
    localparam int EW    = SCW + KCW + 2;

    state_t state_reg, state_next;

    logic [SEC_CFG_BITS-1:0]  sectors_reg;
    logic [SLOT_CFG_BITS-1:0] slots_reg;
    logic [SECTORS-1:0]       used_reg, used_next;
    logic [SW-1:0] rd_sec_reg, rd_sec_next, cur_sec_reg, cur_sec_next, wr_sec_reg, wr_sec_next;
    logic [KW-1:0] rd_slot_reg, rd_slot_next, cur_slot_reg, cur_slot_next;
    logic [KW-1:0] wr_slot_reg, wr_slot_next;
    logic [AW-1:0] sweep_addr_reg, sweep_addr_next, sweep_last_reg, sweep_last_next;
    logic          report_reg, report_next;
    logic [2:0]    cmd_reg;
    logic [31:0]   obj_reg;
    logic          status_reg, status_next;
    logic [31:0]   fetched_reg, fetched_next;
    logic          out_valid_reg;
    out_word_t     out_reg;

    logic [SCW-1:0] nsec;
    logic [KCW-1:0] nslots;
    logic [SW-1:0]  nxt_sec;
    logic [10:0]    estimate;
    logic           out_free;
    logic           accept;
    logic           cfg_hit;

    // slot mark and object memories
    logic [1:0]             mark_mem [TOTAL];
    logic [OBJECT_BITS-1:0] obj_mem  [TOTAL];
    logic                   mark_we, obj_we;
    logic [AW-1:0]          mark_waddr, rd_addr;
    logic [1:0]             mark_wdata, mark_rd_reg;
    logic [OBJECT_BITS-1:0] obj_rd_reg;

    function automatic logic [SW+KW-1:0] step_slot(input logic [SW-1:0] s,
        input logic [KW-1:0] k, input logic [SCW-1:0] ns, input logic [KCW-1:0] nk);
        logic [KCW:0] k1;
        logic [SCW:0] s1;
        logic [SW-1:0] so;
        logic [KW-1:0] ko;
        k1 = (KCW+1)'(k) + 1'b1;
        s1 = (SCW+1)'(s) + 1'b1;
        if (k1 >= (KCW+1)'(nk))
        begin
            ko = '0;
            so = (s1 >= (SCW+1)'(ns)) ? '0 : SW'(s1);
        end
        else
        begin
            ko = KW'(k1);
            so = s;
        end
        return {so, ko};
    endfunction

    function automatic logic [SW-1:0] step_sector(input logic [SW-1:0] s,
        input logic [SCW-1:0] ns);
        logic [SCW:0] s1;
        s1 = (SCW+1)'(s) + 1'b1;
        return (s1 >= (SCW+1)'(ns)) ? '0 : SW'(s1);
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] s, input logic [KW-1:0] k);
        return AW'(AW'(s) * AW'(SLOTS)) + AW'(k);
    endfunction

    // clamp the ring size registers
    always_comb
    begin
        if (sectors_reg < 5'd3)
            nsec = SCW'(3);
        else if (32'(sectors_reg) > SECTORS)
            nsec = SCW'(SECTORS);
        else
            nsec = SCW'(sectors_reg);
        if (slots_reg == '0)
            nslots = KCW'(1);
        else if (32'(slots_reg) > SLOTS)
            nslots = KCW'(SLOTS);
        else
            nslots = KCW'(slots_reg);
    end

    assign nxt_sec = step_sector(wr_sec_reg, nsec);

    // count estimate from the read head to the write head
    always_comb
    begin
        logic [SCW-1:0] diff;
        logic [EW-1:0]  prod;
        logic [EW-1:0]  cnt;
        if (wr_sec_reg >= rd_sec_reg)
            diff = SCW'(wr_sec_reg) - SCW'(rd_sec_reg);
        else
            diff = SCW'(wr_sec_reg) + nsec - SCW'(rd_sec_reg);
        prod = EW'(diff) * EW'(nslots);
        cnt  = prod + EW'(wr_slot_reg) - EW'(rd_slot_reg);
        estimate = cnt[EW-1] ? '0 : 11'(cnt);
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index == REG_SECTORS || cfg_index == REG_SLOTS);
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (sweep_addr_reg == sweep_last_reg)
                    state_next = report_reg ? ST_DONE : ST_IDLE;
            ST_IDLE:
                if (in_valid)
                begin
                    unique case (in_word.cmd)
                        CMD_FORMAT:  state_next = ST_CLEAR;
                        CMD_APPEND:  state_next = used_reg[nxt_sec] ? ST_FREE : ST_APPEND;
                        CMD_FETCH:   state_next = ST_FETCH_RD;
                        CMD_DISCARD: state_next = ST_DISCARD;
                        default:     state_next = ST_DONE;
                    endcase
                end
            ST_FREE:
                if (sweep_addr_reg == sweep_last_reg)
                    state_next = ST_APPEND;
            ST_APPEND:
                state_next = ST_DONE;
            ST_FETCH_RD:
                if (cur_sec_reg == wr_sec_reg && cur_slot_reg == wr_slot_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_FETCH_CHK;
            ST_FETCH_CHK:
                state_next = (mark_rd_reg == MARK_VALID) ? ST_DONE : ST_FETCH_RD;
            ST_DISCARD:
                if (rd_sec_reg == cur_sec_reg && rd_slot_reg == cur_slot_reg)
                    state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
        if (cfg_hit)
            state_next = ST_CLEAR;
    end

    // datapath and memory controls
    always_comb
    begin
        logic [SW+KW-1:0] p;
        used_next       = used_reg;
        rd_sec_next     = rd_sec_reg;
        rd_slot_next    = rd_slot_reg;
        cur_sec_next    = cur_sec_reg;
        cur_slot_next   = cur_slot_reg;
        wr_sec_next     = wr_sec_reg;
        wr_slot_next    = wr_slot_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_last_next = sweep_last_reg;
        report_next     = report_reg;
        status_next     = status_reg;
        fetched_next    = fetched_reg;
        mark_we         = 1'b0;
        mark_waddr      = sweep_addr_reg;
        mark_wdata      = MARK_ERASED;
        obj_we          = 1'b0;
        rd_addr         = addr_of(cur_sec_reg, cur_slot_reg);
        p               = '0;
        unique case (state_reg)
            ST_CLEAR, ST_FREE:
            begin
                mark_we         = 1'b1;
                sweep_addr_next = sweep_addr_reg + 1'b1;
            end
            ST_IDLE:
                if (in_valid)
                begin
                    status_next  = 1'b0;
                    fetched_next = '0;
                    unique case (in_word.cmd)
                        CMD_FORMAT:
                        begin
                            used_next       = '0;
                            rd_sec_next     = '0;
                            rd_slot_next    = '0;
                            cur_sec_next    = '0;
                            cur_slot_next   = '0;
                            wr_sec_next     = '0;
                            wr_slot_next    = '0;
                            sweep_addr_next = '0;
                            sweep_last_next = AW'(TOTAL - 1);
                            report_next     = 1'b1;
                        end
                        CMD_APPEND:
                            if (used_reg[nxt_sec])
                            begin
                                // move heads past the sector being erased
                                if (rd_sec_reg == nxt_sec)
                                begin
                                    rd_sec_next  = step_sector(rd_sec_reg, nsec);
                                    rd_slot_next = '0;
                                end
                                if (cur_sec_reg == nxt_sec)
                                begin
                                    cur_sec_next  = step_sector(cur_sec_reg, nsec);
                                    cur_slot_next = '0;
                                end
                                used_next[nxt_sec] = 1'b0;
                                sweep_addr_next = addr_of(nxt_sec, '0);
                                sweep_last_next = addr_of(nxt_sec, '0) + AW'(SLOTS - 1);
                            end
                        CMD_FETCH:
                            status_next = 1'b1;
                        CMD_REWIND:
                        begin
                            cur_sec_next  = rd_sec_reg;
                            cur_slot_next = rd_slot_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            ST_APPEND:
            begin
                used_next[wr_sec_reg] = 1'b1;
                mark_we    = 1'b1;
                obj_we     = 1'b1;
                mark_waddr = addr_of(wr_sec_reg, wr_slot_reg);
                mark_wdata = MARK_VALID;
                p = step_slot(wr_sec_reg, wr_slot_reg, nsec, nslots);
                {wr_sec_next, wr_slot_next} = p;
            end
            ST_FETCH_CHK:
            begin
                p = step_slot(cur_sec_reg, cur_slot_reg, nsec, nslots);
                {cur_sec_next, cur_slot_next} = p;
                if (mark_rd_reg == MARK_VALID)
                begin
                    status_next  = 1'b0;
                    fetched_next = 32'(obj_rd_reg);
                end
            end
            ST_DISCARD:
                if (!(rd_sec_reg == cur_sec_reg && rd_slot_reg == cur_slot_reg))
                begin
                    mark_we    = 1'b1;
                    mark_waddr = addr_of(rd_sec_reg, rd_slot_reg);
                    mark_wdata = MARK_GARBAGE;
                    p = step_slot(rd_sec_reg, rd_slot_reg, nsec, nslots);
                    {rd_sec_next, rd_slot_next} = p;
                end
            default:
            begin
            end
        endcase
        // register write formats the log
        if (cfg_hit)
        begin
            used_next       = '0;
            rd_sec_next     = '0;
            rd_slot_next    = '0;
            cur_sec_next    = '0;
            cur_slot_next   = '0;
            wr_sec_next     = '0;
            wr_slot_next    = '0;
            sweep_addr_next = '0;
            sweep_last_next = AW'(TOTAL - 1);
            report_next     = 1'b0;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[mark_waddr] <= mark_wdata;
        mark_rd_reg <= mark_mem[rd_addr];
        if (obj_we)
            obj_mem[addr_of(wr_sec_reg, wr_slot_reg)] <= OBJECT_BITS'(obj_reg);
        obj_rd_reg <= obj_mem[rd_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            sectors_reg    <= SEC_CFG_RESET;
            slots_reg      <= SLOT_CFG_RESET;
            used_reg       <= '0;
            rd_sec_reg     <= '0;
            rd_slot_reg    <= '0;
            cur_sec_reg    <= '0;
            cur_slot_reg   <= '0;
            wr_sec_reg     <= '0;
            wr_slot_reg    <= '0;
            sweep_addr_reg <= '0;
            sweep_last_reg <= AW'(TOTAL - 1);
            report_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            rd_sec_reg     <= rd_sec_next;
            rd_slot_reg    <= rd_slot_next;
            cur_sec_reg    <= cur_sec_next;
            cur_slot_reg   <= cur_slot_next;
            wr_sec_reg     <= wr_sec_next;
            wr_slot_reg    <= wr_slot_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
            report_reg     <= report_next;
            if (cfg_valid && cfg_index == REG_SECTORS)
                sectors_reg <= SEC_CFG_BITS'(cfg_data);
            if (cfg_valid && cfg_index == REG_SLOTS)
                slots_reg <= SLOT_CFG_BITS'(cfg_data);
            // hold the result word until taken
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        fetched_reg <= fetched_next;
        if (accept)
        begin
            cmd_reg <= in_word.cmd;
            obj_reg <= in_word.object_word;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_reg.status         <= status_reg;
            out_reg.fetched_word   <= fetched_reg;
            out_reg.count_estimate <= estimate;
        end
    end

    // heads stay inside the ring outside a register write
    assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_valid |=> (SCW'(wr_sec_reg) < nsec) && (SCW'(rd_sec_reg) < nsec)
                       && (SCW'(cur_sec_reg) < nsec))
        else $error("head sector outside the ring");

    assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_valid |=> (KCW'(wr_slot_reg) < nslots) && (KCW'(rd_slot_reg) < nslots))
        else $error("head slot outside the sector");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && out_stall) |=> $stable(out_reg))
        else $error("waiting result word overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPEND) |-> (cmd_reg == CMD_APPEND))
        else $error("slot written by a command other than append");

endmodule
